// ----- design/hqcs_pkg.sv -----
// Shared types and constants of the height quad color shader.
package hqcs_pkg;

   // Widths of the corner heights, their four-way sum and one color channel.
   localparam int HEIGHT_W  = 16;
   localparam int PAIR_W    = HEIGHT_W + 1;
   localparam int SUM_W     = HEIGHT_W + 2;
   localparam int CHANNEL_W = 8;

   // Band limits on the raw sum of the four heights (mean is sum / 4).
   localparam logic signed [SUM_W-1:0] SUM_DEEP       = -18'sd2048;
   localparam logic signed [SUM_W-1:0] SUM_RAMP       = -18'sd512;
   localparam logic signed [SUM_W-1:0] SUM_SHALLOW    = -18'sd128;
   localparam logic signed [SUM_W-1:0] SUM_BEACH      = 18'sd192;
   localparam logic signed [SUM_W-1:0] SUM_GRASS_LOW  = 18'sd1600;
   localparam logic signed [SUM_W-1:0] SUM_GRASS_HIGH = 18'sd3520;
   localparam logic signed [SUM_W-1:0] SUM_ROCK       = 18'sd4160;

   // Ramp bands divide by a constant through a scaled reciprocal. The slope
   // factor of each ramp is folded into its multiplier; with this shift the
   // rounded-up reciprocal gives the exact floor over each band's range.
   localparam int DIV_SHIFT = 28;
   localparam int RAMP_ARG_W = 11;
   localparam int RAMP_MUL_W = 26;
   localparam int RAMP_PROD_W = RAMP_ARG_W + RAMP_MUL_W;

   localparam logic [RAMP_MUL_W-1:0] MUL_BEACH =
      RAMP_MUL_W'(63 * ((2**DIV_SHIFT + 320 - 1) / 320));
   localparam logic [RAMP_MUL_W-1:0] MUL_GRASS_LOW =
      RAMP_MUL_W'(63 * ((2**DIV_SHIFT + 1408 - 1) / 1408));
   localparam logic [RAMP_MUL_W-1:0] MUL_GRASS_HIGH =
      RAMP_MUL_W'(63 * ((2**DIV_SHIFT + 1920 - 1) / 1920));
   localparam logic [RAMP_MUL_W-1:0] MUL_ROCK =
      RAMP_MUL_W'(95 * ((2**DIV_SHIFT + 640 - 1) / 640));

   // Base levels of the color formulas.
   localparam logic [CHANNEL_W-1:0] DEPTH_MAX      = 8'd144;
   localparam logic [CHANNEL_W-1:0] DEPTH_RAMP_OFS = 8'd80;
   localparam logic [CHANNEL_W-1:0] WATER_GREEN    = 8'd224;
   localparam logic [CHANNEL_W-1:0] WATER_BLUE     = 8'd255;
   localparam logic [CHANNEL_W-1:0] OFS_BEACH      = 8'd96;
   localparam logic [CHANNEL_W-1:0] OFS_GRASS_LOW  = 8'd192;
   localparam logic [CHANNEL_W-1:0] OFS_GRASS_HIGH = 8'd128;
   localparam logic [CHANNEL_W-1:0] OFS_ROCK       = 8'd96;
   localparam logic [CHANNEL_W-1:0] SNOW_RED       = 8'd192;
   localparam logic [CHANNEL_W-1:0] SNOW_GREEN     = 8'd224;
   localparam logic [4:0]           SNOW_STEP_MAX  = 5'd31;

   // Slope light limits.
   localparam logic signed [SUM_W-1:0] LIGHT_MIN = -18'sd96;
   localparam logic signed [SUM_W-1:0] LIGHT_MAX = 18'sd95;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height_nw;
      logic signed [HEIGHT_W-1:0] height_ne;
      logic signed [HEIGHT_W-1:0] height_sw;
      logic signed [HEIGHT_W-1:0] height_se;
   } req_payload_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] red_out;
      logic [CHANNEL_W-1:0] green_out;
      logic [CHANNEL_W-1:0] blue_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] red;
      logic [CHANNEL_W-1:0] green;
      logic [CHANNEL_W-1:0] blue;
   } color_type;

endpackage

// ----- design/hqcs_band_color.sv -----
// Height band selection and base color of one quad from its height sum.
module hqcs_band_color import hqcs_pkg::*; (
   input  logic signed [SUM_W-1:0] quad_sum,
   output color_type               base_color
);

   typedef enum logic [2:0] {
      BAND_DEEP,
      BAND_RAMP,
      BAND_SHALLOW,
      BAND_BEACH,
      BAND_GRASS_LOW,
      BAND_GRASS_HIGH,
      BAND_ROCK,
      BAND_SNOW
   } band_type;

   band_type                   band;
   logic signed [SUM_W-1:0]    neg_sum;
   logic signed [SUM_W-1:0]    ramp_diff;
   logic signed [SUM_W-1:0]    snow_diff;
   logic [RAMP_ARG_W-1:0]      mul_arg;
   logic [RAMP_MUL_W-1:0]      mul_key;
   logic [CHANNEL_W-1:0]       ramp_offset;
   logic [RAMP_PROD_W-1:0]     ramp_prod;
   logic [CHANNEL_W-1:0]       ramp_value;
   logic [RAMP_ARG_W-1:0]      shallow_triple;
   logic [CHANNEL_W-1:0]       depth;
   logic [4:0]                 snow_step;

   // Band decision on the raw sum.
   always_comb begin
      if (quad_sum < SUM_DEEP) begin
         band = BAND_DEEP;
      end else if (quad_sum < SUM_RAMP) begin
         band = BAND_RAMP;
      end else if (quad_sum < SUM_SHALLOW) begin
         band = BAND_SHALLOW;
      end else if (quad_sum < SUM_BEACH) begin
         band = BAND_BEACH;
      end else if (quad_sum < SUM_GRASS_LOW) begin
         band = BAND_GRASS_LOW;
      end else if (quad_sum < SUM_GRASS_HIGH) begin
         band = BAND_GRASS_HIGH;
      end else if (quad_sum < SUM_ROCK) begin
         band = BAND_ROCK;
      end else begin
         band = BAND_SNOW;
      end
   end

   // The four linear ramps share one constant multiplier; only the distance
   // into the band, the folded reciprocal and the offset change.
   always_comb begin
      case (band)
         BAND_BEACH: begin
            ramp_diff   = quad_sum - SUM_SHALLOW;
            mul_key     = MUL_BEACH;
            ramp_offset = OFS_BEACH;
         end
         BAND_GRASS_LOW: begin
            ramp_diff   = quad_sum - SUM_BEACH;
            mul_key     = MUL_GRASS_LOW;
            ramp_offset = OFS_GRASS_LOW;
         end
         BAND_GRASS_HIGH: begin
            ramp_diff   = quad_sum - SUM_GRASS_LOW;
            mul_key     = MUL_GRASS_HIGH;
            ramp_offset = OFS_GRASS_HIGH;
         end
         BAND_ROCK: begin
            ramp_diff   = quad_sum - SUM_GRASS_HIGH;
            mul_key     = MUL_ROCK;
            ramp_offset = OFS_ROCK;
         end
         default: begin
            ramp_diff   = '0;
            mul_key     = '0;
            ramp_offset = '0;
         end
      endcase
   end

   assign mul_arg    = ramp_diff[RAMP_ARG_W-1:0];
   assign ramp_prod  = RAMP_PROD_W'(mul_arg) * RAMP_PROD_W'(mul_key);
   assign ramp_value = ramp_prod[DIV_SHIFT +: CHANNEL_W] + ramp_offset;

   // Water depth: the ramp takes one step per 32 of sum, the shallow band
   // three steps per 16. Both only see sums below zero.
   assign neg_sum        = -quad_sum;
   assign shallow_triple = {neg_sum[9:0], 1'b0} + RAMP_ARG_W'(neg_sum[9:0]);

   always_comb begin
      case (band)
         BAND_RAMP:    depth = DEPTH_RAMP_OFS + CHANNEL_W'(neg_sum[11:5]);
         BAND_SHALLOW: depth = CHANNEL_W'(shallow_triple[10:4]);
         default:      depth = DEPTH_MAX;
      endcase
   end

   // Snow brightens by one step per 64 of sum and stops after 31 steps.
   assign snow_diff = quad_sum - SUM_ROCK;
   assign snow_step = (snow_diff[SUM_W-1:6] > 12'(SNOW_STEP_MAX)) ?
                      SNOW_STEP_MAX : snow_diff[10:6];

   always_comb begin
      case (band)
         BAND_DEEP, BAND_RAMP, BAND_SHALLOW: begin
            base_color.red   = '0;
            base_color.green = WATER_GREEN - depth;
            base_color.blue  = WATER_BLUE - depth;
         end
         BAND_BEACH: begin
            base_color.red   = ramp_value;
            base_color.green = ramp_value;
            base_color.blue  = '0;
         end
         BAND_GRASS_LOW, BAND_GRASS_HIGH: begin
            base_color.red   = '0;
            base_color.green = ramp_value;
            base_color.blue  = '0;
         end
         BAND_ROCK: begin
            base_color.red   = ramp_value;
            base_color.green = '0;
            base_color.blue  = '0;
         end
         default: begin
            base_color.red   = SNOW_RED + CHANNEL_W'(snow_step);
            base_color.green = SNOW_GREEN + CHANNEL_W'(snow_step);
            base_color.blue  = SNOW_GREEN + CHANNEL_W'(snow_step);
         end
      endcase
   end

endmodule

// ----- design/height_quad_color_shader_top.sv -----
// Top level of the height quad color shader: handshake, slope light, result register.
//
//   Channel   Ports             Direction   Contents
//   request   req_valid/stall   in          four corner heights of one quad
//   response  rsp_valid/stall   out         red, green and blue of that quad
//   control   csr_write_*       in          slope shading enable
//
// One quad passes through two registers: the request register holds the
// heights, and the color is computed combinationally from it into the
// response register, which takes it once it is empty or its color is being
// transferred. One quad is taken every cycle while the response side flows.
// A synchronous active-high reset empties both registers and turns slope
// shading off. A response stall holds the response register; the request
// register still takes a quad while the response register is full, so the
// request side only stalls when both registers are occupied.
module height_quad_color_shader_top import hqcs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic            csr_write_data
);

   logic                         stage_valid_ff;
   logic                         stage_valid_in;
   req_payload_type              stage_payload_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   rsp_payload_type              rsp_payload_ff;
   rsp_payload_type              rsp_payload_in;
   logic                         enable_ff;
   logic                         enable_in;
   logic                         rsp_load;

   logic signed [PAIR_W-1:0]     sum_top;
   logic signed [PAIR_W-1:0]     sum_bottom;
   logic signed [SUM_W-1:0]      quad_sum;
   logic signed [SUM_W-1:0]      slope_diff;
   logic signed [CHANNEL_W-1:0]  light;
   color_type                    base_color;

   // Adds the slope light to one channel and saturates to 0..255.
   function automatic logic [CHANNEL_W-1:0] shade_channel(
      input logic [CHANNEL_W-1:0]        base,
      input logic signed [CHANNEL_W-1:0] lift
   );
      logic signed [CHANNEL_W+1:0] total;
      total = signed'({2'b00, base}) + signed'({{2{lift[CHANNEL_W-1]}}, lift});
      if (total < 10'sd0) begin
         return '0;
      end else if (total > 10'sd255) begin
         return '1;
      end
      return total[CHANNEL_W-1:0];
   endfunction

   // The response register takes a new color when it is empty or its
   // current one is being transferred; the request register moves with it.
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = stage_valid_ff && !rsp_load;

   assign stage_valid_in = req_stall ? stage_valid_ff : req_valid;
   assign rsp_valid_in   = rsp_load ? stage_valid_ff : rsp_valid_ff;
   assign enable_in      = csr_write_enable ? csr_write_data : enable_ff;

   // Height sums. The north pair is the top edge, the south pair the bottom.
   assign sum_top    = PAIR_W'(stage_payload_ff.height_nw) +
                       PAIR_W'(stage_payload_ff.height_ne);
   assign sum_bottom = PAIR_W'(stage_payload_ff.height_sw) +
                       PAIR_W'(stage_payload_ff.height_se);
   assign quad_sum   = SUM_W'(sum_top) + SUM_W'(sum_bottom);
   assign slope_diff = SUM_W'(sum_bottom) - SUM_W'(sum_top);

   hqcs_band_color u_band_color (
      .quad_sum   (quad_sum),
      .base_color (base_color)
   );

   // The slope light is the south-minus-north difference, limited to -96..95.
   always_comb begin
      if (slope_diff < LIGHT_MIN) begin
         light = LIGHT_MIN[CHANNEL_W-1:0];
      end else if (slope_diff > LIGHT_MAX) begin
         light = LIGHT_MAX[CHANNEL_W-1:0];
      end else begin
         light = slope_diff[CHANNEL_W-1:0];
      end
   end

   always_comb begin
      if (enable_ff) begin
         rsp_payload_in.red_out   = shade_channel(base_color.red, light);
         rsp_payload_in.green_out = shade_channel(base_color.green, light);
         rsp_payload_in.blue_out  = shade_channel(base_color.blue, light);
      end else begin
         rsp_payload_in.red_out   = base_color.red;
         rsp_payload_in.green_out = base_color.green;
         rsp_payload_in.blue_out  = base_color.blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         enable_ff      <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         enable_ff      <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         stage_payload_ff <= req_payload;
      end
      if (rsp_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The request side may only stall while a quad waits in the request register.
   a_stall_needs_stage: assert property (
      @(posedge clock) disable iff (reset) req_stall |-> stage_valid_ff
   ) else $error("request stall without a quad in the request register");

   // A waiting quad moves on whenever the response register frees up.
   a_stage_advances: assert property (
      @(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_load) |=> rsp_valid_ff
   ) else $error("quad in the request register was not moved to the response");

   // A request transfer always leaves a quad in the request register.
   a_transfer_fills_stage: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stage_valid_ff
   ) else $error("accepted quad was lost");

   // A control write takes effect on the next cycle.
   a_csr_write: assert property (
      @(posedge clock) disable iff (reset)
      csr_write_enable |=> (enable_ff == $past(csr_write_data))
   ) else $error("slope shading enable did not follow the write");

endmodule

// ----- dv/height_quad_color_shader_top_tb.sv -----
// Self-checking testbench of the height quad color shader top level.
`timescale 1ns / 1ps

module height_quad_color_shader_top_tb;
   import hqcs_pkg::*;

   // Whether a table row carries its own expected color or leaves it to the predictor.
   localparam logic CHECK_MODEL = 1'b0;
   localparam logic CHECK_TYPED = 1'b1;
   localparam logic SHADE_OFF   = 1'b0;
   localparam logic SHADE_ON    = 1'b1;

   // Random items per phase; four phases alternate slope shading off and on.
   localparam int RANDOM_PHASES    = 4;
   localparam int QUADS_PER_PHASE  = 500;
   // The slowest correct run is roughly 2000 items, so this limit leaves ample margin.
   localparam int CYCLE_LIMIT      = 400000;
   localparam int MAX_WAIT         = 11;

   typedef struct packed {
      logic            shade;
      req_payload_type quad;
      logic            typed;
      rsp_payload_type color;
   } quad_row_type;

   logic            clock            = 1'b0;
   logic            reset            = 1'b1;
   logic            req_valid        = 1'b0;
   logic            req_stall;
   req_payload_type req_payload      = '0;
   logic            rsp_valid;
   logic            rsp_stall        = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic            csr_write_data   = 1'b0;

   // Our copy of the slope shading register, updated on every write we make.
   logic            shade_enable     = SHADE_OFF;

   rsp_payload_type expected_colors [$];
   quad_row_type    quad_table [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int req_quiet      = 0;
   int rsp_quiet      = 0;

   height_quad_color_shader_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The run ends here if the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic int clamp_int(input int value, input int lo, input int hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   // Computes the color of one quad. The sum of the four raw heights is 4
   // times the mean, so every band boundary and ramp works on that sum. All
   // divisions here have a non-negative numerator, so truncation is the floor.
   function automatic rsp_payload_type shade_quad(input req_payload_type quad,
                                                  input logic slope_on);
      int nw, ne, sw, se;
      int sum, depth, level, light;
      int red, green, blue;
      rsp_payload_type color;
      nw  = $signed(quad.height_nw);
      ne  = $signed(quad.height_ne);
      sw  = $signed(quad.height_sw);
      se  = $signed(quad.height_se);
      sum = nw + ne + sw + se;
      if (sum < -128) begin
         // Water: deep, deep ramp and shallow share one color from the depth.
         if (sum < -2048)
            depth = 144;
         else if (sum < -512)
            depth = 80 + (-sum) / 32;
         else
            depth = (3 * (-sum)) / 16;
         red   = 0;
         green = 224 - depth;
         blue  = 255 - depth;
      end else if (sum < 192) begin
         level = ((sum + 128) * 63) / 320 + 96;
         red   = level;
         green = level;
         blue  = 0;
      end else if (sum < 1600) begin
         red   = 0;
         green = ((sum - 192) * 63) / 1408 + 192;
         blue  = 0;
      end else if (sum < 3520) begin
         red   = 0;
         green = ((sum - 1600) * 63) / 1920 + 128;
         blue  = 0;
      end else if (sum < 4160) begin
         red   = ((sum - 3520) * 95) / 640 + 96;
         green = 0;
         blue  = 0;
      end else begin
         level = (sum - 4160) / 64;
         if (level > 31) level = 31;
         red   = level + 192;
         green = level + 224;
         blue  = level + 224;
      end
      if (slope_on) begin
         light = clamp_int((sw + se) - (nw + ne), -96, 95);
         red   = clamp_int(red + light, 0, 255);
         green = clamp_int(green + light, 0, 255);
         blue  = clamp_int(blue + light, 0, 255);
      end
      color.red_out   = 8'(red);
      color.green_out = 8'(green);
      color.blue_out  = 8'(blue);
      return color;
   endfunction

   task report_mismatch(input string message);
      $display("[%0t] mismatch: %s", $realtime, message);
      mismatch_count++;
   endtask

   // Draws how many cycles one side waits before its next transfer. Now and
   // then a stretch of items follows with no waiting at all.
   task automatic draw_wait(inout int quiet_left, output int cycles);
      if (quiet_left > 0) begin
         quiet_left--;
         cycles = 0;
      end else begin
         cycles = $urandom_range(0, MAX_WAIT);
         if ($urandom_range(0, 31) == 0)
            quiet_left = $urandom_range(10, 60);
      end
   endtask

   task automatic add_row(input logic shade, input int nw, input int ne, input int sw,
                          input int se, input logic typed, input rsp_payload_type color);
      quad_row_type row;
      row.shade            = shade;
      row.quad.height_nw   = 16'(nw);
      row.quad.height_ne   = 16'(ne);
      row.quad.height_sw   = 16'(sw);
      row.quad.height_se   = 16'(se);
      row.typed            = typed;
      row.color            = color;
      quad_table.push_back(row);
   endtask

   // Offers one quad and returns at the edge of its transfer. Valid stays high
   // after the transfer, so the next call either replaces the payload in the
   // same step or lowers valid for its idle gap; it is never dropped and
   // raised again within one step.
   task automatic send_quad(input req_payload_type quad, input logic typed,
                            input rsp_payload_type typed_color);
      int gap;
      draw_wait(req_quiet, gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= quad;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed)
         expected_colors.push_back(typed_color);
      else
         expected_colors.push_back(shade_quad(quad, shade_enable));
   endtask

   // Stops offering quads and waits until every expected color has come back.
   task automatic drain_colors();
      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
   endtask

   // The register is only written with the block idle.
   task automatic write_shading(input logic enable);
      drain_colors();
      csr_write_enable <= 1'b1;
      csr_write_data   <= enable;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shade_enable = enable;
   endtask

   // Most random quads sit near the band range with a small slope, so every
   // band and both sides of the light clamp are reached often. The rest use
   // full-scale heights or the extremes of the field.
   function automatic req_payload_type random_quad();
      req_payload_type quad;
      int center;
      case ($urandom_range(0, 7))
         0, 1: begin
            quad = {$urandom, $urandom};
         end
         2: begin
            quad.height_nw = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            quad.height_ne = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            quad.height_sw = ($urandom_range(0, 1) != 0) ? 16'sh0000 : 16'shffff;
            quad.height_se = 16'($urandom);
         end
         default: begin
            center = $urandom_range(0, 10800);
            center = (center - 3600) / 4;
            quad.height_nw = 16'(center + $urandom_range(0, 100) - 50);
            quad.height_ne = 16'(center + $urandom_range(0, 100) - 50);
            quad.height_sw = 16'(center + $urandom_range(0, 100) - 50);
            quad.height_se = 16'(center + $urandom_range(0, 100) - 50);
         end
      endcase
      return quad;
   endfunction

   // Response side: before each transfer the stall is held high for a drawn
   // number of cycles, then released until a color is taken.
   initial begin
      int hold;
      wait (!reset);
      forever begin
         draw_wait(rsp_quiet, hold);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Every color transfer is compared with the oldest expectation.
   always @(posedge clock) begin : color_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            report_mismatch($sformatf("color %h arrived with none expected", rsp_payload));
         end else begin
            want = expected_colors.pop_front();
            if (rsp_payload.red_out !== want.red_out ||
                rsp_payload.green_out !== want.green_out ||
                rsp_payload.blue_out !== want.blue_out)
               report_mismatch($sformatf("rgb got %h %h %h, want %h %h %h",
                  rsp_payload.red_out, rsp_payload.green_out, rsp_payload.blue_out,
                  want.red_out, want.green_out, want.blue_out));
         end
      end
   end

   initial begin
      int phase;
      int n;

      // Band boundaries with shading off: the register still holds its reset
      // value here. Each boundary is taken from both sides.
      add_row(SHADE_OFF,      0,      0,      0,      0, CHECK_MODEL, '0);
      add_row(SHADE_OFF, -32768, -32768, -32768, -32768, CHECK_TYPED,
              {8'd0, 8'd80, 8'd111});
      add_row(SHADE_OFF,  32767,  32767,  32767,  32767, CHECK_TYPED,
              {8'd223, 8'd255, 8'd255});
      add_row(SHADE_OFF,  -2049,      0,      0,      0, CHECK_MODEL, '0);
      add_row(SHADE_OFF,      0,  -2048,      0,      0, CHECK_MODEL, '0);
      add_row(SHADE_OFF,      0,      0,   -513,      0, CHECK_MODEL, '0);
      add_row(SHADE_OFF,      0,      0,      0,   -512, CHECK_MODEL, '0);
      add_row(SHADE_OFF,    -65,    -64,      0,      0, CHECK_MODEL, '0);
      add_row(SHADE_OFF,      0,      0,    -64,    -64, CHECK_MODEL, '0);
      add_row(SHADE_OFF,     48,     48,     48,     47, CHECK_MODEL, '0);
      add_row(SHADE_OFF,     48,     48,     48,     48, CHECK_MODEL, '0);
      add_row(SHADE_OFF,   1599,      0,      0,      0, CHECK_MODEL, '0);
      add_row(SHADE_OFF,    400,    400,    400,    400, CHECK_MODEL, '0);
      add_row(SHADE_OFF,      0,   3519,      0,      0, CHECK_MODEL, '0);
      add_row(SHADE_OFF,    880,    880,    880,    880, CHECK_MODEL, '0);
      add_row(SHADE_OFF,      0,      0,   4159,      0, CHECK_MODEL, '0);
      add_row(SHADE_OFF,   1040,   1040,   1040,   1040, CHECK_MODEL, '0);
      add_row(SHADE_OFF,   1536,   1536,   1536,   1536, CHECK_MODEL, '0);
      // With shading on: both sides of each light clamp, saturation at both
      // ends of a channel, and the largest slope, with the south edge high.
      add_row(SHADE_ON,       0,      0,     48,     48, CHECK_MODEL, '0);
      add_row(SHADE_ON,       0,      0,     47,     48, CHECK_MODEL, '0);
      add_row(SHADE_ON,      48,     49,      0,      0, CHECK_MODEL, '0);
      add_row(SHADE_ON,      48,     48,      0,      0, CHECK_MODEL, '0);
      add_row(SHADE_ON,       0,      0,   3072,   3072, CHECK_TYPED,
              {8'd255, 8'd255, 8'd255});
      add_row(SHADE_ON,       0,      0,  -2000,  -2000, CHECK_TYPED,
              {8'd0, 8'd0, 8'd15});
      add_row(SHADE_ON,  -32768, -32768,  32767,  32767, CHECK_MODEL, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (quad_table[i]) begin
         if (quad_table[i].shade != shade_enable)
            write_shading(quad_table[i].shade);
         send_quad(quad_table[i].quad, quad_table[i].typed, quad_table[i].color);
      end

      // Random phases. Each one starts with a register write, which first
      // pauses the request side until every expected color has been taken.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_shading(phase[0]);
         for (n = 0; n < QUADS_PER_PHASE; n++)
            send_quad(random_quad(), CHECK_MODEL, '0);
      end

      // Let the pipeline empty, then watch for any stray color transfer before the verdict.
      drain_colors();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/hqcs_pkg.sv
design/hqcs_band_color.sv
design/height_quad_color_shader_top.sv
dv/height_quad_color_shader_top_tb.sv
